// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the character mapping of the base64 stream encoder.
package b64e_pkg;

	localparam logic [1:0] MODE_STD       = 2'd0;
	localparam logic [1:0] MODE_URL_PAD   = 2'd1;
	localparam logic [1:0] MODE_URL_NOPAD = 2'd2;

	localparam logic [6:0] PAD_CHAR = 7'h3d;

	// One queued run: the characters caused by one input byte.
	// Positions 0 and 1 carry alphabet indexes, positions 2 and 3 are always padding.
	typedef struct packed {
		logic [5:0] idx0;
		logic [5:0] idx1;
		logic [1:0] last;
		logic       fin;
	} b64e_entry_t;

	function automatic logic [6:0] enc_char(input logic [5:0] idx, input logic url);
		logic [6:0] ch;
		if (idx inside {[6'd0:6'd25]}) begin
			ch = 7'd65 + {1'b0, idx};
		end else if (idx inside {[6'd26:6'd51]}) begin
			ch = 7'd71 + {1'b0, idx};
		end else if (idx inside {[6'd52:6'd61]}) begin
			ch = {1'b0, idx} - 7'd4;
		end else if (idx == 6'd62) begin
			ch = url ? 7'h2d : 7'h2b;
		end else begin
			ch = url ? 7'h5f : 7'h2f;
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/b64e_if.sv =====
// Valid/ready channel interfaces for message bytes and encoded characters.
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       final_byte;

	modport source(output valid, byte_in, final_byte, input ready);
	modport sink(input valid, byte_in, final_byte, output ready);
endinterface

interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       end_of_message;
	logic       last_of_run;

	modport source(output valid, out_char, end_of_message, last_of_run, input ready);
	modport sink(input valid, out_char, end_of_message, last_of_run, output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
// Front end: accepts message bytes, tracks the group phase and builds one run per byte.
module b64e_front (
	input  logic                 clk,
	input  logic                 arst_n,
	b64e_in_if.sink              msg,
	input  logic [1:0]           mode,
	input  logic                 push_ready,
	output logic                 push,
	output b64e_pkg::b64e_entry_t push_data
);
	import b64e_pkg::*;

	localparam logic [1:0] PH0 = 2'd0;
	localparam logic [1:0] PH1 = 2'd1;
	localparam logic [1:0] PH2 = 2'd2;

	logic [1:0] phase_q;
	logic [5:0] carry_q;
	logic [1:0] phase_n;
	logic [5:0] carry_n;
	logic [5:0] sym0;
	logic [5:0] sym1;
	logic [1:0] last_run;
	logic [1:0] last_fin;
	logic       pads;
	logic       acc;

	assign msg.ready = push_ready;
	assign acc       = msg.valid && push_ready;
	assign push      = acc;
	assign pads      = (mode == MODE_STD) || (mode == MODE_URL_PAD);

	always_comb begin
		case (phase_q)
			PH1: begin
				sym0     = carry_q | {2'b00, msg.byte_in[7:4]};
				carry_n  = {msg.byte_in[3:0], 2'b00};
				sym1     = carry_n;
				phase_n  = PH2;
				last_run = 2'd0;
				last_fin = pads ? 2'd2 : 2'd1;
			end
			PH2: begin
				sym0     = carry_q | {4'b0000, msg.byte_in[7:6]};
				carry_n  = 6'd0;
				sym1     = msg.byte_in[5:0];
				phase_n  = PH0;
				last_run = 2'd1;
				last_fin = 2'd1;
			end
			default: begin
				sym0     = msg.byte_in[7:2];
				carry_n  = {msg.byte_in[1:0], 4'b0000};
				sym1     = carry_n;
				phase_n  = PH1;
				last_run = 2'd0;
				last_fin = pads ? 2'd3 : 2'd1;
			end
		endcase
	end

	always_comb begin
		push_data.idx0 = sym0;
		push_data.idx1 = sym1;
		push_data.last = msg.final_byte ? last_fin : last_run;
		push_data.fin  = msg.final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH0;
			carry_q <= 6'd0;
		end else if (acc) begin
			// A final byte closes the message and starts a fresh group.
			phase_q <= msg.final_byte ? PH0 : phase_n;
			carry_q <= msg.final_byte ? 6'd0 : carry_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_final_restarts_group: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && msg.final_byte) |=> (phase_q == PH0 && carry_q == 6'd0))
		else $error("group state not cleared after final beat");
	a_phase_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH0) || (phase_q == PH1) || (phase_q == PH2))
		else $error("group phase left its cycle");
`endif

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Small run queue between the front end and the character emitter.
module b64e_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64e_pkg::b64e_entry_t wr_data,
	output logic                  push_ready,
	input  logic                  pop,
	output logic                  rd_valid,
	output b64e_pkg::b64e_entry_t rd_data
);
	import b64e_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64e_entry_t     slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign rd_valid   = (count_q != '0);
	assign rd_data    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !push_ready))
		else $error("run queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !rd_valid))
		else $error("run queue read while empty");
`endif

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end: walks each queued run and issues one character per beat into the output register.
module b64e_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            mode,
	input  logic                  head_valid,
	input  b64e_pkg::b64e_entry_t head,
	output logic                  pop,
	b64e_out_if.source            chars
);
	import b64e_pkg::*;

	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       eom_q;
	logic       lor_q;
	logic [1:0] pos_q;
	logic       load;
	logic       last_sym;
	logic [6:0] char_n;

	assign load     = head_valid && (!out_valid_q || chars.ready);
	assign last_sym = (pos_q == head.last);
	assign pop      = load && last_sym;

	always_comb begin
		case (pos_q)
			2'd0:    char_n = enc_char(head.idx0, mode != MODE_STD);
			2'd1:    char_n = enc_char(head.idx1, mode != MODE_STD);
			default: char_n = PAD_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= last_sym ? 2'd0 : pos_q + 2'd1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= char_n;
			eom_q      <= last_sym && head.fin;
			lor_q      <= last_sym;
		end
	end

	assign chars.valid          = out_valid_q;
	assign chars.out_char       = out_char_q;
	assign chars.end_of_message = eom_q;
	assign chars.last_of_run    = lor_q;

`ifndef NO_ASSERTIONS
	a_pos_within_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (pos_q <= head.last))
		else $error("character position ran past the end of its run");
	a_pos_rewinds_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (pos_q == 2'd0))
		else $error("character position not rewound after run");
`endif

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// Streaming base64 encoder: one message byte per input beat, one character per output beat.
// The front end accepts a byte in the cycle it arrives whenever the run queue has room and
// turns it into a run of one to four characters; the emitter then sends one character per
// cycle, while the output is ready, through a registered output. A full 3-byte group
// yields four characters, and a final byte with padding yields up to four. The output port is
// the limit, and the queue of QUEUE_DEPTH runs lets input and output stall independently.
// alphabet_mode selects: 0 standard alphabet with '=' padding, 1 url-safe with padding,
// 2 (or 3) url-safe without padding; write it only while the encoder is idle.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	b64e_in_if.sink    msg,
	b64e_out_if.source chars
);
	import b64e_pkg::*;

	logic [1:0]  alphabet_mode_q;
	logic        push;
	logic        push_ready;
	logic        pop;
	logic        head_valid;
	b64e_entry_t push_data;
	b64e_entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_mode_q <= MODE_STD;
		end else if (cfg_we) begin
			alphabet_mode_q <= cfg_wdata;
		end
	end

	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.mode      (alphabet_mode_q),
		.push_ready(push_ready),
		.push      (push),
		.push_data (push_data)
	);

	b64e_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (push_data),
		.push_ready(push_ready),
		.pop       (pop),
		.rd_valid  (head_valid),
		.rd_data   (head)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (alphabet_mode_q),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.chars     (chars)
	);

endmodule

// ===== bench/base64_stream_encoder_test.sv =====
// Self-checking testbench for the streaming base64 encoder with random stalls on both sides.
`timescale 1ns / 100ps

module base64_stream_encoder_test;
	import b64e_pkg::*;

	// The spare mode code behaves like url-safe without padding.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_BYTES = 54;

	typedef enum logic [1:0] {ACT_BYTE, ACT_MODE, ACT_DRAIN} act_kind_t;

	typedef struct {
		act_kind_t  kind;
		logic [7:0] data;
		logic       fin;
	} stim_act_t;

	typedef struct {
		logic [6:0] ch;
		logic       eom;
		logic       lor;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	b64e_in_if  msg_if();
	b64e_out_if chars_if();

	base64_stream_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.msg       (msg_if.sink),
		.chars     (chars_if.source)
	);

	string std_tab = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	string url_tab = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	// Encoder state as predicted by the bench.
	logic [1:0] enc_mode = MODE_STD;
	logic [1:0] enc_phase = 2'd0;
	logic [5:0] enc_carry = 6'd0;

	stim_act_t  pending[$];
	char_beat_t char_queue[$];
	char_beat_t want_beat;
	stim_act_t  act;

	int  bytes_planned = 0;
	int  bytes_taken = 0;
	int  fail_count = 0;
	int  idle_cycles = 0;
	int  send_gap = 0;
	int  recv_wait = 0;
	bit  beat_taken = 1'b0;
	bit  char_taken = 1'b0;
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;
	logic next_valid;
	logic next_we;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Wait drawn per beat; now and then a side switches to a stretch with no idling at all.
	function automatic int draw_wait(ref bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [6:0] char_of(input logic [5:0] idx);
		byte c;
		if (enc_mode == MODE_STD)
			c = std_tab[idx];
		else
			c = url_tab[idx];
		return c[6:0];
	endfunction

	// Works out the characters that one accepted message byte releases.
	function automatic void encode_byte(input logic [7:0] b, input logic fin);
		logic [6:0] run[4];
		int n;
		int pads;
		char_beat_t beat;
		n = 0;
		case (enc_phase)
			2'd1: begin
				run[n++] = char_of(enc_carry | {2'b00, b[7:4]});
				enc_carry = {b[3:0], 2'b00};
				enc_phase = 2'd2;
				pads = 1;
			end
			2'd2: begin
				run[n++] = char_of(enc_carry | {4'b0000, b[7:6]});
				run[n++] = char_of(b[5:0]);
				enc_carry = 6'd0;
				enc_phase = 2'd0;
				pads = -1;
			end
			default: begin
				run[n++] = char_of(b[7:2]);
				enc_carry = {b[1:0], 4'b0000};
				enc_phase = 2'd1;
				pads = 2;
			end
		endcase
		if (fin) begin
			if (pads >= 0) begin
				run[n++] = char_of(enc_carry);
				if (enc_mode < MODE_URL_NOPAD) begin
					for (int k = 0; k < pads; k++)
						run[n++] = PAD_CHAR;
				end
			end
			enc_phase = 2'd0;
			enc_carry = 6'd0;
		end
		for (int k = 0; k < n; k++) begin
			beat.ch = run[k];
			beat.lor = (k == n - 1);
			beat.eom = fin && (k == n - 1);
			char_queue.push_back(beat);
		end
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic fin);
		stim_act_t a;
		a.kind = ACT_BYTE;
		a.data = b;
		a.fin = fin;
		pending.push_back(a);
		bytes_planned++;
	endtask

	task automatic add_mode(input logic [1:0] m);
		stim_act_t a;
		a.kind = ACT_MODE;
		a.data = {6'd0, m};
		a.fin = 1'b0;
		pending.push_back(a);
	endtask

	task automatic add_drain();
		stim_act_t a;
		a.kind = ACT_DRAIN;
		a.data = 8'd0;
		a.fin = 1'b0;
		pending.push_back(a);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Driver: presents message beats and register writes at the falling edge.
	always @(negedge clk) begin
		next_valid = msg_if.valid;
		next_we = 1'b0;
		if (arst_n) begin
			if (beat_taken) begin
				beat_taken = 1'b0;
				next_valid = 1'b0;
				send_gap = draw_wait(send_calm);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending.size() > 0) begin
					act = pending[0];
					case (act.kind)
						ACT_BYTE: begin
							pending.delete(0);
							msg_if.byte_in <= act.data;
							msg_if.final_byte <= act.fin;
							next_valid = 1'b1;
						end
						ACT_MODE: begin
							if (char_queue.size() == 0) begin
								pending.delete(0);
								cfg_wdata <= act.data[1:0];
								next_we = 1'b1;
							end
						end
						default: begin
							if (char_queue.size() == 0)
								pending.delete(0);
						end
					endcase
				end
			end
		end
		msg_if.valid <= next_valid;
		cfg_we <= next_we;
	end

	// Receiver stalls: after each accepted character, ready may drop for a drawn wait.
	always @(negedge clk) begin
		if (char_taken) begin
			char_taken = 1'b0;
			recv_wait = draw_wait(recv_calm);
		end
		if (recv_wait > 0) begin
			recv_wait--;
			chars_if.ready <= 1'b0;
		end else begin
			chars_if.ready <= 1'b1;
		end
	end

	// Monitor: predicts on every accepted byte and checks every accepted character.
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg_if.valid && msg_if.ready) begin
				encode_byte(msg_if.byte_in, msg_if.final_byte);
				beat_taken = 1'b1;
				bytes_taken++;
			end
			if (cfg_we)
				enc_mode = cfg_wdata;
			if (chars_if.valid && chars_if.ready) begin
				char_taken = 1'b1;
				if (char_queue.size() == 0) begin
					$error("unexpected character 0x%0h", chars_if.out_char);
					fail_count++;
				end else begin
					want_beat = char_queue.pop_front();
					if (chars_if.out_char !== want_beat.ch) begin
						$error("out_char: expected 0x%0h, got 0x%0h", want_beat.ch,
							chars_if.out_char);
						fail_count++;
					end
					if (chars_if.end_of_message !== want_beat.eom) begin
						$error("end_of_message: expected %0b, got %0b", want_beat.eom,
							chars_if.end_of_message);
						fail_count++;
					end
					if (chars_if.last_of_run !== want_beat.lor) begin
						$error("last_of_run: expected %0b, got %0b", want_beat.lor,
							chars_if.last_of_run);
						fail_count++;
					end
				end
			end
			if ((msg_if.valid && msg_if.ready) || (chars_if.valid && chars_if.ready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("** base64_stream_encoder: FAILED **");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [1:0] phase_modes[6];
		int phase_count;
		int len;
		bit drain_done;

		msg_if.valid = 1'b0;
		msg_if.byte_in = 8'h00;
		msg_if.final_byte = 1'b0;
		chars_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_STD;
		drain_done = 1'b0;

		// Directed: bytes that reach indexes 62 and 63, and a message ending in each phase.
		phase_modes[0] = MODE_STD;
		phase_modes[1] = MODE_URL_PAD;
		phase_modes[2] = MODE_URL_NOPAD;
		for (int m = 0; m < 3; m++) begin
			add_mode(phase_modes[m]);
			add_byte(8'hfb, 1'b0);
			add_byte(8'hff, 1'b0);
			add_byte(8'hbf, 1'b1);
			add_byte(8'h00, 1'b1);
			add_byte(8'hff, 1'b0);
			add_byte(8'h7f, 1'b1);
		end

		phase_modes = '{MODE_URL_NOPAD, MODE_STD, MODE_SPARE, MODE_URL_PAD, MODE_STD,
			MODE_URL_NOPAD};
		for (int p = 0; p < 6; p++) begin
			add_mode(phase_modes[p]);
			phase_count = 0;
			while (phase_count < PHASE_BYTES) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					// Once, the sender holds off until the output has drained.
					if (p == 1 && !drain_done && phase_count >= PHASE_BYTES / 2) begin
						add_drain();
						drain_done = 1'b1;
					end
					add_byte(pick_byte(), k == len - 1);
					phase_count++;
				end
			end
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		while (bytes_taken < bytes_planned || char_queue.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** base64_stream_encoder: PASSED **");
		else
			$display("** base64_stream_encoder: FAILED **");
		$finish;
	end

endmodule
